### rtl/vector_angle_to_steer_command_unit_defines.svh
// Assertion macros shared by the steering unit
`ifndef VECTOR_ANGLE_TO_STEER_COMMAND_UNIT_DEFINES_SVH
`define VECTOR_ANGLE_TO_STEER_COMMAND_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define VAS_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication checked outside reset
`define VAS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### rtl/vas_pkg.sv
package vas_pkg;
	localparam int TABLE_LEN = 24;
	localparam logic [0:0] CFG_GAIN  = 1'b0;
	localparam logic [0:0] CFG_LIMIT = 1'b1;
	localparam logic [15:0] GAIN_RESET  = 16'd37540;
	localparam logic [14:0] LIMIT_RESET = 15'd9532;

	// atan(2^-i) as a fraction of a full turn, scaled by 2^32
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
				5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
				5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
				5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
				5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
				5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
				5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
				5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
				5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
				5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
				5'd20: r = 32'd652;       5'd21: r = 32'd326;
				5'd22: r = 32'd163;       5'd23: r = 32'd81;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction
endpackage

### rtl/vector_angle_to_steer_command_unit.sv
// Angle between two vectors and a steering command. One item is taken per
// cycle while the output register is empty or is being read; each item passes
// the CORDIC pre-rotation and rotation stages (one stage per rotation) and then
// the angle, scaling and clamping stages. The whole pipe advances whenever the
// output register is empty or is being read, so stalls lose nothing.
module vector_angle_to_steer_command_unit import vas_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int ACOS_ITERATIONS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// a_x, a_y, b_x, b_y from bit 0 up
	input  logic [4*COORD_WIDTH-1:0] s_axis_tdata,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// angle_deg, turn_left, steer_value, zero_vector, steer_clipped; zero fill
	output logic [39:0]              m_axis_tdata,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [0:0]               cfg_index,
	input  logic [15:0]              cfg_data
);
	`include "vector_angle_to_steer_command_unit_defines.svh"

	localparam int CW = COORD_WIDTH;
	localparam int N = (ACOS_ITERATIONS < TABLE_LEN) ? ACOS_ITERATIONS : TABLE_LEN;
	localparam int D = N + 1;

	logic [15:0] gain_q;
	logic [14:0] limit_q;
	logic        en;

	// config registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_GAIN:  gain_q  <= cfg_data;
				CFG_LIMIT: limit_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic signed [CW-1:0] ax, ay, bx, by;
	assign ax = s_axis_tdata[CW-1:0];
	assign ay = s_axis_tdata[2*CW-1:CW];
	assign bx = s_axis_tdata[3*CW-1:2*CW];
	assign by = s_axis_tdata[4*CW-1:3*CW];

	logic [31:0] dir_a, dir_b;
	vas_cordic #(.CW(CW), .ITER(ACOS_ITERATIONS)) u_cord_a (
		.clk(clk), .en(en), .x(ax), .y(ay), .dir(dir_a));
	vas_cordic #(.CW(CW), .ITER(ACOS_ITERATIONS)) u_cord_b (
		.clk(clk), .en(en), .x(bx), .y(by), .dir(dir_b));

	// side flags travel alongside the rotations
	logic [D-1:0] vld_s, left_s, zero_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s <= '0;
		else if (en) vld_s <= {vld_s[D-2:0], s_axis_tvalid};
	end
	always_ff @(posedge clk) begin
		if (en) begin
			left_s <= {left_s[D-2:0], ax > bx};
			zero_s <= {zero_s[D-2:0], (ax == 0 && ay == 0) || (bx == 0 && by == 0)};
		end
	end

	// stage A: fold direction difference onto half a turn
	logic [31:0] d_raw, d_fold;
	logic [31:0] d_sa;
	logic        v_sa, l_sa, z_sa;
	assign d_raw  = dir_a - dir_b;
	assign d_fold = (d_raw > 32'h8000_0000) ? (32'd0 - d_raw) : d_raw;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sa <= 1'b0;
		else if (en) v_sa <= vld_s[D-1];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d_sa <= d_fold;
			l_sa <= left_s[D-1];
			z_sa <= zero_s[D-1];
		end
	end

	// stage B: scale to Q8.8 degrees
	logic [37:0] prod45;
	logic [15:0] ang_sb;
	logic        v_sb, l_sb, z_sb;
	assign prod45 = 38'(d_sa) * 38'd45 + 38'(1 << 20);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sb <= 1'b0;
		else if (en) v_sb <= v_sa;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ang_sb <= z_sa ? 16'd0 : prod45[36:21];
			l_sb   <= l_sa;
			z_sb   <= z_sa;
		end
	end

	// stage C: multiply by gain
	logic [32:0] mag_full;
	logic [15:0] mag_sc, ang_sc;
	logic        v_sc, l_sc, z_sc;
	assign mag_full = 33'(ang_sb) * 33'(gain_q) + 33'(1 << 16);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sc <= 1'b0;
		else if (en) v_sc <= v_sb;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mag_sc <= mag_full[32:17];
			ang_sc <= ang_sb;
			l_sc   <= l_sb;
			z_sc   <= z_sb;
		end
	end

	// stage D: clamp, sign and hold the result
	logic        clip;
	logic [15:0] mag_c, steer;
	logic [15:0] ang_q, steer_q;
	logic        l_q, z_q, clip_q;
	assign clip  = !z_sc && (mag_sc > {1'b0, limit_q});
	assign mag_c = z_sc ? 16'd0 : (clip ? {1'b0, limit_q} : mag_sc);
	assign steer = l_sc ? mag_c : (16'd0 - mag_c);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (en) m_axis_tvalid <= v_sc;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ang_q   <= ang_sc;
			steer_q <= steer;
			l_q     <= l_sc;
			z_q     <= z_sc;
			clip_q  <= clip;
		end
	end

	assign m_axis_tdata = {5'd0, clip_q, z_q, steer_q, l_q, ang_q};

	`VAS_ASSERT_IMPL(a_zero_quiet, clk, arst_n, m_axis_tvalid && z_q,
		ang_q == 16'd0 && steer_q == 16'd0 && !clip_q, "zero vector with nonzero result")
	`VAS_ASSERT_IMPL(a_angle_range, clk, arst_n, m_axis_tvalid,
		ang_q <= 16'd46080, "angle above half a turn")
	`VAS_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule

### rtl/vas_cordic.sv
// Pipelined CORDIC vectoring: one micro-rotation per stage, advancing on en
module vas_cordic import vas_pkg::*; #(
	parameter int CW = 16,
	parameter int ITER = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] x,
	input  logic signed [CW-1:0] y,
	output logic [31:0]          dir
);
	// grows by about one bit over the rotations, plus sign of negation
	localparam int W = CW + 3;
	localparam int N = (ITER < TABLE_LEN) ? ITER : TABLE_LEN;

	logic signed [W-1:0] x_s [0:N];
	logic signed [W-1:0] y_s [0:N];
	logic [31:0]         a_s [0:N];

	// pre-rotate left half-plane by half a turn
	always_ff @(posedge clk) begin
		if (en) begin
			if (x < 0) begin
				x_s[0] <= -W'(x);
				y_s[0] <= -W'(y);
				a_s[0] <= 32'h8000_0000;
			end else begin
				x_s[0] <= W'(x);
				y_s[0] <= W'(y);
				a_s[0] <= 32'd0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] + atan_turn(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] - atan_turn(5'(i));
				end
			end
		end
	end

	assign dir = a_s[N];
endmodule
